// ===== hw/rtl/pus_pkg.sv =====
`default_nettype none

package pus_pkg;

    typedef enum logic [2:0] {
        K_STATIC,
        K_FIRE,
        K_EXPLODE,
        K_EXPLODE2,
        K_BLOB,
        K_BLOB2,
        K_GRAV,
        K_SLOWGRAV
    } t_kind;

    typedef enum logic [2:0] {
        CFG_FRAME_TIME,
        CFG_GRAVITY_STEP,
        CFG_NOW_TIME,
        CFG_VIEW_X,
        CFG_VIEW_Y,
        CFG_VIEW_Z,
        CFG_VIEW_OFFSET,
        CFG_SIZE_FACTOR
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic        [23:0] ramp_pos;
        t_kind              kind;
        logic signed [31:0] death_time;
        logic        [7:0]  palette_index;
    } t_in_beat;

    typedef struct packed {
        logic               retired;
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_pos_z;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
        logic        [23:0] new_ramp;
        logic signed [31:0] new_death_time;
        logic        [7:0]  new_palette_index;
        logic        [30:0] draw_scale;
        logic        [16:0] fade_alpha;
    } t_out_beat;

    typedef struct packed {
        logic        [19:0] frame_time;
        logic signed [23:0] gravity_step;
        logic        [30:0] now_time;
        logic signed [17:0] view_x;
        logic signed [17:0] view_y;
        logic signed [17:0] view_z;
        logic signed [31:0] view_offset;
        logic        [19:0] size_factor;
    } t_cfg;

    // kinematic result after the third stage
    typedef struct packed {
        logic               retired;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic        [23:0] ramp;
        logic signed [31:0] death;
        logic        [7:0]  pal;
        logic        [16:0] alpha;
    } t_kin;

    typedef struct packed {
        logic signed [49:0] q_x;
        logic signed [49:0] q_y;
        logic signed [49:0] q_z;
    } t_vprod;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic [7:0] fire_pal(input logic [2:0] i);
        logic [7:0] r;
        case (i)
            3'd0: r = 8'h6d;
            3'd1: r = 8'h6b;
            3'd2: r = 8'h06;
            3'd3: r = 8'h05;
            3'd4: r = 8'h04;
            3'd5: r = 8'h03;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] expl_pal(input logic [2:0] i);
        logic [7:0] r;
        case (i)
            3'd0: r = 8'h6f;
            3'd1: r = 8'h6d;
            3'd2: r = 8'h6b;
            3'd3: r = 8'h69;
            3'd4: r = 8'h67;
            3'd5: r = 8'h65;
            3'd6: r = 8'h63;
            default: r = 8'h61;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] expl2_pal(input logic [2:0] i);
        logic [7:0] r;
        case (i)
            3'd0: r = 8'h6f;
            3'd1: r = 8'h6e;
            3'd2: r = 8'h6d;
            3'd3: r = 8'h6c;
            3'd4: r = 8'h6b;
            3'd5: r = 8'h6a;
            3'd6: r = 8'h68;
            default: r = 8'h66;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pus_kin.sv =====
`default_nettype none

module pus_kin #(
    parameter int FRAC_BITS = 16
) (
    input  wire               i_clk,
    input  wire         [2:0] i_en,
    input  pus_pkg::t_in_beat i_beat,
    input  pus_pkg::t_cfg     i_cfg,
    output pus_pkg::t_kin     o_kin,
    output pus_pkg::t_vprod   o_vp
);
    import pus_pkg::*;

    localparam logic [31:0]        FIRE_END = 32'(64'd6 << FRAC_BITS);
    localparam logic [31:0]        EXPL_END = 32'(64'd8 << FRAC_BITS);
    localparam logic signed [31:0] NEG_ONE  = 32'(-(64'sd1 <<< FRAC_BITS));
    localparam logic signed [63:0] ONE      = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] HALF     = ONE >>> 1;

    // stage 1
    t_in_beat           r1_beat;
    logic signed [52:0] r1_p [3];
    logic        [25:0] r1_sum;
    logic               r1_retire;

    logic        [3:0]  ramp_mul;
    logic        [24:0] ramp_step;
    logic signed [20:0] ft_s;

    always_comb begin
        case (i_beat.kind)
            K_FIRE:     ramp_mul = 4'd5;
            K_EXPLODE:  ramp_mul = 4'd10;
            K_EXPLODE2: ramp_mul = 4'd15;
            default:    ramp_mul = 4'd0;
        endcase
        ramp_step = 25'(i_cfg.frame_time) * 25'(ramp_mul);
        ft_s      = $signed({1'b0, i_cfg.frame_time});
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_beat   <= i_beat;
            r1_p[0]   <= i_beat.vel_x * ft_s;
            r1_p[1]   <= i_beat.vel_y * ft_s;
            r1_p[2]   <= i_beat.vel_z * ft_s;
            r1_sum    <= 26'(i_beat.ramp_pos) + 26'(ramp_step);
            r1_retire <= $signed({i_beat.death_time[31], i_beat.death_time})
                         < $signed({2'b00, i_cfg.now_time});
        end
    end

    // stage 2: move, ramp, velocity scaling
    logic signed [31:0] pin  [3];
    logic signed [31:0] vin  [3];
    logic signed [52:0] f1   [3];
    logic signed [52:0] f4   [3];
    logic signed [63:0] dv   [3];
    logic signed [31:0] n_pos [3];
    logic signed [31:0] n_vel [3];
    logic        [23:0] n_ramp;
    logic signed [31:0] n_death;
    logic        [7:0]  n_pal;
    logic        [31:0] ramp_w;
    logic        [31:0] ramp_int;

    assign pin[0] = r1_beat.pos_x;
    assign pin[1] = r1_beat.pos_y;
    assign pin[2] = r1_beat.pos_z;
    assign vin[0] = r1_beat.vel_x;
    assign vin[1] = r1_beat.vel_y;
    assign vin[2] = r1_beat.vel_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            f1[i] = r1_p[i] >>> FRAC_BITS;
            f4[i] = r1_p[i] >>> (FRAC_BITS - 2);
            case (r1_beat.kind)
                K_EXPLODE, K_BLOB: dv[i] = 64'(f4[i]);
                K_EXPLODE2:        dv[i] = -64'(f1[i]);
                K_BLOB2:           dv[i] = (i < 2) ? -64'(f4[i]) : 64'sd0;
                default:           dv[i] = 64'sd0;
            endcase
            n_pos[i] = sat32(64'(pin[i]) + 64'(f1[i]));
            n_vel[i] = sat32(64'(vin[i]) + dv[i]);
        end
        n_ramp   = (r1_sum > 26'hFFFFFF) ? 24'hFFFFFF : r1_sum[23:0];
        ramp_w   = 32'(n_ramp);
        ramp_int = ramp_w >> FRAC_BITS;
        n_death  = r1_beat.death_time;
        n_pal    = r1_beat.palette_index;
        case (r1_beat.kind)
            K_FIRE: begin
                if (ramp_w >= FIRE_END) begin
                    n_death = NEG_ONE;
                end else begin
                    n_pal = fire_pal(ramp_int[2:0]);
                end
            end
            K_EXPLODE: begin
                if (ramp_w >= EXPL_END) begin
                    n_death = NEG_ONE;
                end else begin
                    n_pal = expl_pal(ramp_int[2:0]);
                end
            end
            K_EXPLODE2: begin
                if (ramp_w >= EXPL_END) begin
                    n_death = NEG_ONE;
                end else begin
                    n_pal = expl2_pal(ramp_int[2:0]);
                end
            end
            default: begin
            end
        endcase
    end

    t_kind              r2_kind;
    logic               r2_retire;
    logic signed [31:0] r2_pos [3];
    logic signed [31:0] r2_vel [3];
    logic        [23:0] r2_ramp;
    logic signed [31:0] r2_death;
    logic        [7:0]  r2_pal;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_kind   <= r1_beat.kind;
            r2_retire <= r1_retire;
            r2_pos    <= n_pos;
            r2_vel    <= n_vel;
            r2_ramp   <= n_ramp;
            r2_death  <= n_death;
            r2_pal    <= n_pal;
        end
    end

    // stage 3: gravity, fade, view products
    logic signed [63:0] grav;
    logic signed [63:0] alpha_w;
    logic signed [31:0] n_vz;
    logic        [16:0] n_alpha;

    always_comb begin
        case (r2_kind)
            K_FIRE:   grav = 64'(i_cfg.gravity_step);
            K_STATIC: grav = 64'sd0;
            default:  grav = -64'(i_cfg.gravity_step);
        endcase
        n_vz    = sat32(64'(r2_vel[2]) + grav);
        alpha_w = 64'(r2_death) + HALF - 64'($signed({1'b0, i_cfg.now_time}));
        if (alpha_w < 64'sd0) begin
            n_alpha = '0;
        end else if (alpha_w > ONE) begin
            n_alpha = ONE[16:0];
        end else begin
            n_alpha = alpha_w[16:0];
        end
    end

    t_kin   r3_kin;
    t_vprod r3_vp;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_kin.retired <= r2_retire;
            r3_kin.pos_x   <= r2_pos[0];
            r3_kin.pos_y   <= r2_pos[1];
            r3_kin.pos_z   <= r2_pos[2];
            r3_kin.vel_x   <= r2_vel[0];
            r3_kin.vel_y   <= r2_vel[1];
            r3_kin.vel_z   <= n_vz;
            r3_kin.ramp    <= r2_ramp;
            r3_kin.death   <= r2_death;
            r3_kin.pal     <= r2_pal;
            r3_kin.alpha   <= n_alpha;
            r3_vp.q_x      <= r2_pos[0] * i_cfg.view_x;
            r3_vp.q_y      <= r2_pos[1] * i_cfg.view_y;
            r3_vp.q_z      <= r2_pos[2] * i_cfg.view_z;
        end
    end

    assign o_kin = r3_kin;
    assign o_vp  = r3_vp;

endmodule

`default_nettype wire

// ===== hw/rtl/pus_scale.sv =====
`default_nettype none

module pus_scale #(
    parameter int FRAC_BITS = 16
) (
    input  wire              i_clk,
    input  wire        [3:0] i_en,
    input  pus_pkg::t_vprod  i_vp,
    input  pus_pkg::t_cfg    i_cfg,
    output logic      [30:0] o_draw_scale
);
    import pus_pkg::*;

    localparam int DPW = (53 - FRAC_BITS > 33) ? 53 - FRAC_BITS : 33;
    localparam int XW  = DPW - 1;
    localparam int RW  = XW + 1;
    localparam int XL  = XW / 2;
    localparam int XH  = XW - XL;
    localparam int ML  = RW / 2;
    localparam int MH  = RW - ML;
    localparam int TW  = XW + RW;
    localparam int SCW = XW - 6;
    localparam int PW  = SCW - 1 + 20;

    // floor(x / 250) = (x * RECIP) >> (XW + 8) for any x below 2^XW
    localparam logic [63:0] RECIP    = ((64'd1 << (XW + 8)) + 64'd249) / 64'd250;
    localparam logic [63:0] ONE      = 64'd1 << FRAC_BITS;
    localparam logic [63:0] NEAR_SC  = ONE + (ONE * 64'd8 + 64'd50) / 64'd100;
    localparam logic signed [DPW-1:0] NEAR_LIM = DPW'(64'd20 << FRAC_BITS);
    localparam logic [ML-1:0] M_LO = RECIP[ML-1:0];
    localparam logic [MH-1:0] M_HI = RECIP[RW-1:ML];

    // stage 4: depth
    logic signed [51:0]    vsum;
    logic signed [51:0]    vsh;
    logic signed [DPW-1:0] r4_depth;

    always_comb begin
        vsum = 52'(i_vp.q_x) + 52'(i_vp.q_y) + 52'(i_vp.q_z);
        vsh  = vsum >>> FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r4_depth <= DPW'(vsh) - DPW'(i_cfg.view_offset);
        end
    end

    // stage 5: partial products of the reciprocal multiply
    logic [XL-1:0]    x_lo;
    logic [XH-1:0]    x_hi;
    logic             r5_near;
    logic [XL+ML-1:0] r5_ll;
    logic [XL+MH-1:0] r5_lh;
    logic [XH+ML-1:0] r5_hl;
    logic [XH+MH-1:0] r5_hh;

    assign x_lo = r4_depth[XL-1:0];
    assign x_hi = r4_depth[XW-1:XL];

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r5_near <= r4_depth < NEAR_LIM;
            r5_ll   <= (XL+ML)'(x_lo) * (XL+ML)'(M_LO);
            r5_lh   <= (XL+MH)'(x_lo) * (XL+MH)'(M_HI);
            r5_hl   <= (XH+ML)'(x_hi) * (XH+ML)'(M_LO);
            r5_hh   <= (XH+MH)'(x_hi) * (XH+MH)'(M_HI);
        end
    end

    // stage 6: quotient and half scale
    logic [TW-1:0]  total;
    logic [SCW-1:0] sc;
    logic [SCW-2:0] r6_half;

    always_comb begin
        total = TW'(r5_ll) + (TW'(r5_lh) << ML) + (TW'(r5_hl) << XL)
              + (TW'(r5_hh) << (XL + ML));
        if (r5_near) begin
            sc = SCW'(NEAR_SC);
        end else begin
            sc = SCW'(ONE) + SCW'(total[TW-1:XW+8]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r6_half <= sc[SCW-1:1];
        end
    end

    // stage 7: size compensation
    logic [PW-1:0] r7_prod;

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r7_prod <= PW'(r6_half) * PW'(i_cfg.size_factor);
        end
    end

    logic [63:0] prod_sh;

    always_comb begin
        prod_sh = 64'(r7_prod >> FRAC_BITS);
        o_draw_scale = (prod_sh > 64'h7FFFFFFF) ? 31'h7FFFFFFF : prod_sh[30:0];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/particle_update_step_unit.sv =====
// Particle update step: one particle record per input beat, the record one
// frame later per output beat. Input and output use valid/ready; a beat
// moves when valid and ready are both high. Frame time, gravity, current
// time, view direction, view offset and size factor sit in registers
// written over the config channel (index 0..7, always ready); write them
// only while the unit holds no beat.
// A beat passes from input to output valid through three kinematic
// stages (velocity products, move and ramp, gravity and view products),
// four draw-scale stages (depth sum, reciprocal partial products, quotient,
// size multiply) and the output register. One beat per cycle is sustained
// while the receiver is ready; the multiplier stages set the depth.
// Each stage holds its own valid bit and takes a new beat whenever it is
// empty or its successor moves, so a stalled receiver fills the empty
// stages first and then holds everything in place; input ready drops only
// once all eight stages are full.
// Reset clears all valid bits and loads the register defaults (view along
// +z, size factor 1.27).
`default_nettype none

module particle_update_step_unit #(
    parameter int FRAC_BITS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  pus_pkg::t_in_beat   i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output pus_pkg::t_out_beat  o_out_data,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire           [2:0] i_cfg_index,
    input  wire          [31:0] i_cfg_data
);
    import pus_pkg::*;

    localparam int NS = 8;

    // config registers
    t_cfg     r_cfg;
    t_cfg_idx cfg_idx;

    assign o_cfg_ready = 1'b1;
    assign cfg_idx     = t_cfg_idx'(i_cfg_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_time   <= '0;
            r_cfg.gravity_step <= '0;
            r_cfg.now_time     <= '0;
            r_cfg.view_x       <= '0;
            r_cfg.view_y       <= '0;
            r_cfg.view_z       <= 18'sd65536;
            r_cfg.view_offset  <= '0;
            r_cfg.size_factor  <= 20'd83231;
        end else if (i_cfg_valid) begin
            case (cfg_idx)
                CFG_FRAME_TIME:   r_cfg.frame_time   <= i_cfg_data[19:0];
                CFG_GRAVITY_STEP: r_cfg.gravity_step <= i_cfg_data[23:0];
                CFG_NOW_TIME:     r_cfg.now_time     <= i_cfg_data[30:0];
                CFG_VIEW_X:       r_cfg.view_x       <= i_cfg_data[17:0];
                CFG_VIEW_Y:       r_cfg.view_y       <= i_cfg_data[17:0];
                CFG_VIEW_Z:       r_cfg.view_z       <= i_cfg_data[17:0];
                CFG_VIEW_OFFSET:  r_cfg.view_offset  <= i_cfg_data;
                CFG_SIZE_FACTOR:  r_cfg.size_factor  <= i_cfg_data[19:0];
                default: begin
                end
            endcase
        end
    end

    // stage valids and enables
    logic [NS-1:0] r_vld;
    logic [NS-1:0] stg_en;

    always_comb begin
        stg_en[NS-1] = !r_vld[NS-1] || i_out_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (stg_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready  = stg_en[0];
    assign o_out_valid = r_vld[NS-1];

    t_kin        kin;
    t_vprod      vp;
    logic [30:0] draw_scale;

    pus_kin #(
        .FRAC_BITS (FRAC_BITS)
    ) u_kin (
        .i_clk  (i_clk),
        .i_en   (stg_en[2:0]),
        .i_beat (i_in_data),
        .i_cfg  (r_cfg),
        .o_kin  (kin),
        .o_vp   (vp)
    );

    pus_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .i_clk        (i_clk),
        .i_en         (stg_en[6:3]),
        .i_vp         (vp),
        .i_cfg        (r_cfg),
        .o_draw_scale (draw_scale)
    );

    // kinematic result waits alongside the draw-scale stages
    t_kin r_kd [4];

    always_ff @(posedge i_clk) begin
        if (stg_en[3]) begin
            r_kd[0] <= kin;
        end
        for (int k = 1; k < 4; k++) begin
            if (stg_en[3+k]) begin
                r_kd[k] <= r_kd[k-1];
            end
        end
    end

    t_out_beat n_out;
    t_out_beat r_out;

    always_comb begin
        n_out = '0;
        n_out.retired = r_kd[3].retired;
        if (!r_kd[3].retired) begin
            n_out.new_pos_x         = r_kd[3].pos_x;
            n_out.new_pos_y         = r_kd[3].pos_y;
            n_out.new_pos_z         = r_kd[3].pos_z;
            n_out.new_vel_x         = r_kd[3].vel_x;
            n_out.new_vel_y         = r_kd[3].vel_y;
            n_out.new_vel_z         = r_kd[3].vel_z;
            n_out.new_ramp          = r_kd[3].ramp;
            n_out.new_death_time    = r_kd[3].death;
            n_out.new_palette_index = r_kd[3].pal;
            n_out.draw_scale        = draw_scale;
            n_out.fade_alpha        = r_kd[3].alpha;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[NS-1]) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

    a_retired_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.retired |->
            o_out_data.draw_scale == '0 && o_out_data.new_pos_x == '0
            && o_out_data.fade_alpha == '0)
        else $error("retired beat carries data");

    a_first_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] && !stg_en[1] |=> r_vld[0])
        else $error("stalled first stage lost its beat");

    a_last_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NS-1] && !i_out_ready |=> r_vld[NS-1] && $stable(r_out))
        else $error("stalled output changed");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[0] |-> o_in_ready)
        else $error("empty first stage refused a beat");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pus_pkg::*;

    localparam int  ONE         = 65536;
    localparam int  CYCLE_LIMIT = 400000;
    localparam longint I32_MAX  = 64'sd2147483647;
    localparam longint I32_MIN  = -64'sd2147483648;

    typedef struct {
        t_in_beat  beat;
        bit        typed;
        t_out_beat result;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in_beat    in_data;
    logic        out_valid;
    logic        out_ready;
    t_out_beat   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    t_cfg_idx    cfg_index;
    logic [31:0] cfg_data;

    // register shadow
    logic        [19:0] r_frame;
    logic signed [23:0] r_grav;
    logic        [30:0] r_now;
    logic signed [17:0] r_vx, r_vy, r_vz;
    logic signed [31:0] r_offset;
    logic        [19:0] r_size;

    logic [7:0] fire_ramp_pal  [8] = '{8'h6d, 8'h6b, 8'h06, 8'h05, 8'h04, 8'h03, 8'h00, 8'h00};
    logic [7:0] burst_ramp_pal [8] = '{8'h6f, 8'h6d, 8'h6b, 8'h69, 8'h67, 8'h65, 8'h63, 8'h61};
    logic [7:0] burst2_ramp_pal[8] = '{8'h6f, 8'h6e, 8'h6d, 8'h6c, 8'h6b, 8'h6a, 8'h68, 8'h66};

    t_out_beat pending_frames[$];
    t_row      directed_rows[$];
    int        errors;
    int        cycles;
    bit        gaps_on;

    particle_update_step_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint clip(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic t_out_beat advance_particle(t_in_beat b);
        longint    p[3], v[3];
        longint    ramp, death, now, ft, grav, depth, sc, alpha;
        logic [7:0] pal;
        t_out_beat r;
        r = '0;
        p[0] = b.pos_x; p[1] = b.pos_y; p[2] = b.pos_z;
        v[0] = b.vel_x; v[1] = b.vel_y; v[2] = b.vel_z;
        ramp  = b.ramp_pos;
        death = b.death_time;
        pal   = b.palette_index;
        now   = r_now;
        ft    = r_frame;
        grav  = r_grav;
        if (death < now) begin
            r.retired = 1'b1;
            return r;
        end
        for (int i = 0; i < 3; i++) p[i] = clip(p[i] + ((v[i] * ft) >>> 16), I32_MIN, I32_MAX);
        case (t_kind'(b.kind))
            K_FIRE: begin
                ramp = clip(ramp + 5 * ft, 0, 24'hFFFFFF);
                if (ramp >= 6 * ONE) death = -ONE;
                else pal = fire_ramp_pal[(ramp >> 16) & 7];
                v[2] = clip(v[2] + grav, I32_MIN, I32_MAX);
            end
            K_EXPLODE: begin
                ramp = clip(ramp + 10 * ft, 0, 24'hFFFFFF);
                if (ramp >= 8 * ONE) death = -ONE;
                else pal = burst_ramp_pal[(ramp >> 16) & 7];
                for (int i = 0; i < 3; i++)
                    v[i] = clip(v[i] + ((v[i] * 4 * ft) >>> 16), I32_MIN, I32_MAX);
                v[2] = clip(v[2] - grav, I32_MIN, I32_MAX);
            end
            K_EXPLODE2: begin
                ramp = clip(ramp + 15 * ft, 0, 24'hFFFFFF);
                if (ramp >= 8 * ONE) death = -ONE;
                else pal = burst2_ramp_pal[(ramp >> 16) & 7];
                for (int i = 0; i < 3; i++)
                    v[i] = clip(v[i] - ((v[i] * ft) >>> 16), I32_MIN, I32_MAX);
                v[2] = clip(v[2] - grav, I32_MIN, I32_MAX);
            end
            K_BLOB: begin
                for (int i = 0; i < 3; i++)
                    v[i] = clip(v[i] + ((v[i] * 4 * ft) >>> 16), I32_MIN, I32_MAX);
                v[2] = clip(v[2] - grav, I32_MIN, I32_MAX);
            end
            K_BLOB2: begin
                for (int i = 0; i < 2; i++)
                    v[i] = clip(v[i] - ((v[i] * 4 * ft) >>> 16), I32_MIN, I32_MAX);
                v[2] = clip(v[2] - grav, I32_MIN, I32_MAX);
            end
            K_GRAV, K_SLOWGRAV: v[2] = clip(v[2] - grav, I32_MIN, I32_MAX);
            default: ;
        endcase
        depth = ((p[0] * longint'(r_vx) + p[1] * longint'(r_vy) + p[2] * longint'(r_vz)) >>> 16)
                - longint'(r_offset);
        if (depth < 20 * ONE) sc = ONE + (ONE * 8 + 50) / 100;
        else sc = ONE + (depth * 4) / 1000;
        sc = sc >>> 1;
        sc = clip((sc * longint'(r_size)) >>> 16, 0, I32_MAX);
        alpha = clip(death + ONE / 2 - now, 0, ONE);
        r.new_pos_x         = p[0][31:0];
        r.new_pos_y         = p[1][31:0];
        r.new_pos_z         = p[2][31:0];
        r.new_vel_x         = v[0][31:0];
        r.new_vel_y         = v[1][31:0];
        r.new_vel_z         = v[2][31:0];
        r.new_ramp          = ramp[23:0];
        r.new_death_time    = death[31:0];
        r.new_palette_index = pal;
        r.draw_scale        = sc[30:0];
        r.fade_alpha        = alpha[16:0];
        return r;
    endfunction

    function automatic void split_frame(t_out_beat o, output logic [31:0] f[12]);
        f[0]  = o.retired;          f[1]  = o.new_pos_x;      f[2]  = o.new_pos_y;
        f[3]  = o.new_pos_z;        f[4]  = o.new_vel_x;      f[5]  = o.new_vel_y;
        f[6]  = o.new_vel_z;        f[7]  = o.new_ramp;       f[8]  = o.new_death_time;
        f[9]  = o.new_palette_index; f[10] = o.draw_scale;    f[11] = o.fade_alpha;
    endfunction

    string field_names[12] = '{"retired", "new_pos_x", "new_pos_y", "new_pos_z",
        "new_vel_x", "new_vel_y", "new_vel_z", "new_ramp", "new_death_time",
        "new_palette_index", "draw_scale", "fade_alpha"};

    always @(posedge i_clk) begin
        logic [31:0] want[12];
        logic [31:0] got[12];
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_frames.size() == 0) begin
                $display("%0t: unexpected output beat %h", $time, out_data);
                errors++;
            end else begin
                split_frame(pending_frames.pop_front(), want);
                split_frame(out_data, got);
                for (int i = 0; i < 12; i++) begin
                    if (want[i] !== got[i]) begin
                        $display("%0t: %s expected %h got %h", $time, field_names[i],
                                 want[i], got[i]);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) out_ready = gaps_on ? ($urandom_range(99) >= 19) : 1'b1;
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge i_clk); while (!cfg_ready);
        case (idx)
            CFG_FRAME_TIME:   r_frame  = value[19:0];
            CFG_GRAVITY_STEP: r_grav   = value[23:0];
            CFG_NOW_TIME:     r_now    = value[30:0];
            CFG_VIEW_X:       r_vx     = value[17:0];
            CFG_VIEW_Y:       r_vy     = value[17:0];
            CFG_VIEW_Z:       r_vz     = value[17:0];
            CFG_VIEW_OFFSET:  r_offset = value;
            default:          r_size   = value[19:0];
        endcase
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain_pipe();
        while (pending_frames.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic load_settings(input logic [31:0] v[8]);
        drain_pipe();
        for (int i = 0; i < 8; i++) write_reg(t_cfg_idx'(i), v[i]);
    endtask

    task automatic send_particle(input t_in_beat b, input bit typed, input t_out_beat r);
        if (gaps_on && $urandom_range(99) < 19) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_data  = b;
        pending_frames.push_back(typed ? r : advance_particle(b));
        do @(posedge i_clk); while (!in_ready);
        @(negedge i_clk);
        in_valid = 1'b0;
    endtask

    function automatic logic [31:0] pick32();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom;
            3: return 32'($signed($urandom_range(0, 255)) - 128) <<< 16;
            default: return 32'($signed($urandom_range(0, 40000000)) - 20000000);
        endcase
    endfunction

    function automatic t_in_beat random_particle();
        t_in_beat b;
        longint   d;
        b.pos_x = pick32(); b.pos_y = pick32(); b.pos_z = pick32();
        b.vel_x = pick32(); b.vel_y = pick32(); b.vel_z = pick32();
        b.kind  = t_kind'($urandom_range(7));
        case ($urandom_range(3))
            0: b.ramp_pos = 24'($urandom);
            1: b.ramp_pos = 24'(6 * ONE - $urandom_range(0, 3000));
            2: b.ramp_pos = 24'(8 * ONE - $urandom_range(0, 3000));
            default: b.ramp_pos = 24'($urandom_range(0, 8 * ONE));
        endcase
        if ($urandom_range(4) == 0) begin
            b.death_time = $urandom;
        end else begin
            d = longint'(r_now) + $urandom_range(0, 200000) - 30000;
            b.death_time = 32'(clip(d, I32_MIN, I32_MAX));
        end
        b.palette_index = 8'($urandom);
        return b;
    endfunction

    task automatic add_row(input logic [31:0] px, py, pz, vx, vy, vz,
                           input logic [23:0] ramp, input t_kind k,
                           input logic [31:0] death, input logic [7:0] pal,
                           input bit typed, input t_out_beat r);
        t_row row;
        row.beat  = '{px, py, pz, vx, vy, vz, ramp, k, death, pal};
        row.typed = typed;
        row.result = r;
        directed_rows.push_back(row);
    endtask

    initial begin
        logic [31:0] regs[8];
        int          sent;
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FRAME_TIME;
        cfg_data  = '0;
        errors    = 0;
        cycles    = 0;
        gaps_on   = 1'b1;
        r_frame = '0; r_grav = '0; r_now = '0; r_vx = '0; r_vy = '0;
        r_vz = 18'sd65536; r_offset = '0; r_size = 20'd83231;

        add_row(0, 0, 0, 0, 0, 0, 0, K_STATIC, 0, 0, 1,
                '{draw_scale: 31'd44944, fade_alpha: 17'd32768, default: '0});
        add_row(5, 6, 7, 8, 9, 10, 11, K_FIRE, 32'hFFFFFFFF, 3, 1,
                '{retired: 1'b1, default: '0});
        add_row(-1, -1, -1, -1, -1, -1, 24'hFFFFFF, K_BLOB, 32'h80000000, 255, 1,
                '{retired: 1'b1, default: '0});
        // fire ramp already at its end: death forced, palette kept
        add_row(0, 0, 0, 0, 0, 0, 24'(6 * ONE), K_FIRE, 32'h7FFFFFFF, 8'h12, 1,
                '{new_ramp: 24'(6 * ONE), new_death_time: -32'sd65536,
                  new_palette_index: 8'h12, draw_scale: 31'd44944, default: '0});
        for (int k = 0; k < 8; k++) begin
            add_row(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                    32'h7FFFFFFF, 32'h7FFFFFFF, 24'hFFFFFF, t_kind'(k),
                    32'h7FFFFFFF, 255, 0, '0);
            add_row(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                    32'h80000000, 32'h80000000, 0, t_kind'(k), 0, 0, 0, '0);
        end
        add_row(0, 0, 20 * ONE, 0, 0, 0, 24'(6 * ONE - 1), K_FIRE, ONE, 1, 0, '0);
        add_row(0, 0, 20 * ONE - 1, 0, 0, 0, 24'(8 * ONE - 1), K_EXPLODE, ONE, 1, 0, '0);
        add_row(0, 0, 32'h40000000, 0, 0, 0, 24'(8 * ONE - 1), K_EXPLODE2, ONE, 1, 0, '0);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i])
            send_particle(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].result);

        sent = 0;
        for (int phase = 0; phase < 9; phase++) begin
            case (phase)
                0: regs = '{32'hFFFFF, 32'h7FFFFF, 0, 65536, 65536, 65536,
                            32'h80000000, 32'hFFFFF};
                1: regs = '{1092, 32'hFF800000, 32'h7FFFFFFF, -65536, -65536, -65536,
                            32'h7FFFFFFF, 0};
                2: regs = '{0, 0, 32'h12345678, -131072, 131071, 0, 0, 83231};
                default: begin
                    regs[0] = $urandom_range(1) ? $urandom_range(0, 4000) : $urandom;
                    regs[1] = $urandom;
                    regs[2] = $urandom_range(1) ? $urandom_range(0, 50000000) : $urandom;
                    regs[3] = $urandom_range(0, 131072) - 65536;
                    regs[4] = $urandom_range(0, 131072) - 65536;
                    regs[5] = $urandom_range(0, 131072) - 65536;
                    regs[6] = $urandom_range(1) ? $urandom : $urandom_range(0, 4000000);
                    regs[7] = $urandom;
                end
            endcase
            load_settings(regs);
            repeat (170) begin
                gaps_on = !(sent >= 600 && sent < 850);
                send_particle(random_particle(), 0, '0);
                sent++;
            end
        end
        in_valid = 1'b0;

        drain_pipe();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/pus_pkg.sv
hw/rtl/pus_kin.sv
hw/rtl/pus_scale.sv
hw/rtl/particle_update_step_unit.sv
tb/testbench.sv
